FILE: rtl/core/hdsh_pkg.sv
`default_nettype none

package hdsh_pkg;

  // Number of regions counted per frame (legal range 1 to 63).
  localparam int REGIONS = 32;
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] REGION_LIMIT = IDX_W'(REGIONS);

  // Field widths.
  localparam int DETAIL_W = 10;
  localparam int SAD_W = 25;
  localparam int FDETAIL_W = 16;
  localparam int HOLD_W = 5;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 8;

  // Per-region thresholds.
  localparam logic [DETAIL_W-1:0] LOW_DETAIL_LIMIT = 10'h3;
  localparam logic [SAD_W-1:0] LOW_SAD_LIMIT = 25'h30;

  // Per-frame count thresholds.
  localparam logic [IDX_W-1:0] DETAIL_COUNT_MIN = 6'd20;
  localparam logic [IDX_W-1:0] SAD_COUNT_MIN = 6'd10;

  // Hold length in frames.
  localparam logic [HOLD_W-1:0] HOLD_FRAMES = 5'd20;

  // Frame detail thresholds.
  localparam logic [FDETAIL_W-1:0] ZMV_HDETAIL_MIN = 16'h1c00;
  localparam logic [FDETAIL_W-1:0] ZMV_VDETAIL_MIN = 16'h0500;
  localparam logic [FDETAIL_W-1:0] RP_HDETAIL_MIN = 16'h4000;
  localparam logic [FDETAIL_W-1:0] RP_VDETAIL_MIN = 16'h2000;

  // Summary of one finished frame, handed to the decision logic.
  typedef struct packed {
    logic sad_ok;
    logic dtl_ok;
    logic still;
    logic zmv_detail_ok;
    logic rp_detail_ok;
  } frame_sum_t;

  // Decision for one frame.
  typedef struct packed {
    logic zero_motion;
    logic repeat_hit;
  } decision_t;

endpackage

`default_nettype wire

FILE: rtl/core/hdsh_decide.sv
`default_nettype none

module hdsh_decide (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   eval,
  input  wire                   detect_enable,
  input  wire hdsh_pkg::frame_sum_t sum,
  output hdsh_pkg::decision_t   decision
);

  logic [hdsh_pkg::HOLD_W-1:0] still_hold_count;
  logic [hdsh_pkg::HOLD_W-1:0] still_hold_count_next;
  logic [hdsh_pkg::HOLD_W-1:0] detail_hold_count;
  logic [hdsh_pkg::HOLD_W-1:0] detail_hold_count_next;
  logic                        repeat_flag;
  logic                        repeat_flag_next;
  logic                        zmv_cond;

  // Zero-motion needs a still frame or a running still hold.
  assign zmv_cond = sum.sad_ok && sum.dtl_ok && sum.zmv_detail_ok &&
                    (sum.still || (still_hold_count != '0));

  // Frame decision and next hold state.
  always_comb begin
    still_hold_count_next  = still_hold_count;
    detail_hold_count_next = detail_hold_count;
    repeat_flag_next       = 1'b0;
    decision.zero_motion   = 1'b0;
    if (detect_enable) begin
      decision.zero_motion = zmv_cond;
      if (zmv_cond) begin
        still_hold_count_next = sum.still ? hdsh_pkg::HOLD_FRAMES
                                          : still_hold_count - 1'b1;
      end else begin
        still_hold_count_next = '0;
      end

      if (sum.sad_ok && sum.rp_detail_ok) begin
        repeat_flag_next       = 1'b1;
        detail_hold_count_next = hdsh_pkg::HOLD_FRAMES;
      end else if (sum.sad_ok && (detail_hold_count != '0)) begin
        // While the hold runs the flag keeps its previous value.
        repeat_flag_next       = repeat_flag;
        detail_hold_count_next = detail_hold_count - 1'b1;
      end else begin
        repeat_flag_next       = 1'b0;
        detail_hold_count_next = '0;
      end
    end
    decision.repeat_hit = repeat_flag_next;
  end

  // Hold state advances once per finished frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      still_hold_count  <= '0;
      detail_hold_count <= '0;
      repeat_flag       <= 1'b0;
    end else if (eval) begin
      still_hold_count  <= still_hold_count_next;
      detail_hold_count <= detail_hold_count_next;
      repeat_flag       <= repeat_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/high_detail_scene_hold_detector_top.sv
// A frame's result is registered in the output register when its last-region item leaves
// the input register, which holds that item while the output is blocked.
// Throughput: one region item per cycle; the input register and the output register
// let items flow back to back, and only a last-region item waits for a free output.
// Reset (rst, synchronous, active high) clears the counts, hold counters, repeat
// flag, detect_enable and both valid flags.
`default_nettype none

module high_detail_scene_hold_detector_top (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          detect_enable_we,
  input  wire                          detect_enable_wdata,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // region_detail[9:0], region_sad[34:10], frame_hdetail[50:35],
  // frame_vdetail[66:51], zero padding[71:67]
  input  wire [hdsh_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  wire                          s_axis_tlast,   // last_region
  input  wire                          s_axis_tuser,   // video_still
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // zero_motion_detected[0], repeat_detected[1], zero padding[7:2]
  output logic [hdsh_pkg::M_DATA_W-1:0] m_axis_tdata
);

  logic                           detect_enable;

  // Input register.
  logic                           in_valid;
  logic [hdsh_pkg::DETAIL_W-1:0]  in_detail;
  logic [hdsh_pkg::SAD_W-1:0]     in_sad;
  logic                           in_last;
  logic [hdsh_pkg::FDETAIL_W-1:0] in_hdetail;
  logic [hdsh_pkg::FDETAIL_W-1:0] in_vdetail;
  logic                           in_still;

  // Per-frame counts.
  logic [hdsh_pkg::IDX_W-1:0]     region_index;
  logic [hdsh_pkg::IDX_W-1:0]     low_detail_count;
  logic [hdsh_pkg::IDX_W-1:0]     low_sad_count;
  logic [hdsh_pkg::IDX_W-1:0]     low_detail_count_next;
  logic [hdsh_pkg::IDX_W-1:0]     low_sad_count_next;
  logic                           counted;

  logic                           advance;
  logic                           eval;
  hdsh_pkg::frame_sum_t           sum;
  hdsh_pkg::decision_t            decision;

  // An item leaves the input register unless it ends a frame and the output is blocked.
  assign advance = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign eval = advance && in_last;
  assign s_axis_tready = !in_valid || advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable <= 1'b0;
    end else if (detect_enable_we) begin
      detect_enable <= detect_enable_wdata;
    end
  end

  // Capture the incoming item.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_detail  <= s_axis_tdata[9:0];
      in_sad     <= s_axis_tdata[34:10];
      in_hdetail <= s_axis_tdata[50:35];
      in_vdetail <= s_axis_tdata[66:51];
      in_last    <= s_axis_tlast;
      in_still   <= s_axis_tuser;
    end
  end

  // Counts including the current region; regions past the limit are ignored.
  always_comb begin
    counted = region_index < hdsh_pkg::REGION_LIMIT;
    low_detail_count_next = low_detail_count +
      hdsh_pkg::IDX_W'(counted && (in_detail < hdsh_pkg::LOW_DETAIL_LIMIT));
    low_sad_count_next = low_sad_count +
      hdsh_pkg::IDX_W'(counted && (in_sad < hdsh_pkg::LOW_SAD_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_index     <= '0;
      low_detail_count <= '0;
      low_sad_count    <= '0;
    end else if (advance) begin
      if (in_last) begin
        region_index     <= '0;
        low_detail_count <= '0;
        low_sad_count    <= '0;
      end else begin
        region_index     <= region_index + hdsh_pkg::IDX_W'(counted);
        low_detail_count <= low_detail_count_next;
        low_sad_count    <= low_sad_count_next;
      end
    end
  end

  // Frame summary for the decision logic.
  always_comb begin
    sum.sad_ok        = low_sad_count_next > hdsh_pkg::SAD_COUNT_MIN;
    sum.dtl_ok        = low_detail_count_next > hdsh_pkg::DETAIL_COUNT_MIN;
    sum.still         = in_still;
    sum.zmv_detail_ok = (in_hdetail > hdsh_pkg::ZMV_HDETAIL_MIN) &&
                        (in_vdetail > hdsh_pkg::ZMV_VDETAIL_MIN);
    sum.rp_detail_ok  = (in_hdetail > hdsh_pkg::RP_HDETAIL_MIN) &&
                        (in_vdetail > hdsh_pkg::RP_VDETAIL_MIN);
  end

  hdsh_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .eval          (eval),
    .detect_enable (detect_enable),
    .sum           (sum),
    .decision      (decision)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (eval) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      m_axis_tdata <= {6'd0, decision.repeat_hit, decision.zero_motion};
    end
  end

`ifndef SYNTHESIS
  // The region counter never passes the configured region limit.
  assert property (@(posedge clk) disable iff (rst)
    region_index <= hdsh_pkg::REGION_LIMIT)
    else $error("region index past limit");

  // Low counts can only grow with counted regions.
  assert property (@(posedge clk) disable iff (rst)
    (low_detail_count <= region_index) && (low_sad_count <= region_index))
    else $error("low count exceeds regions seen");

  // Input stalls only for a frame end waiting on a blocked output.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && in_last && m_axis_tvalid && !m_axis_tready))
    else $error("unexpected input stall");

  // A frame end that advances always produces a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    eval |=> m_axis_tvalid)
    else $error("frame result lost");
`endif

endmodule

`default_nettype wire
